/* rtl/hdc_pkg.sv */
// ----------------------------------------------------------------------------
// hdc_pkg
// Shared types and constants of the PD heading controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hdc_pkg;

    // width of the serial multiplier operand, one bit per cycle
    localparam int MUL_BW    = 32;
    localparam int MUL_CNT_W = $clog2(MUL_BW);

    // 180/pi in Q.24
    localparam logic signed [MUL_BW-1:0] RAD2DEG_Q24 = 32'sd961263669;

    // unity weight in Q1.16
    localparam int LP_ONE = 65536;

    // filter accumulator and its rounded value
    localparam int FILT_W = 52;
    localparam int FR_W   = FILT_W - 16;

    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_DERIV_GAIN    = 3'd1,
        REG_LOWPASS_ALPHA = 3'd2,
        REG_ZERO_COEF     = 3'd3,
        REG_POLE_COEF     = 3'd4,
        REG_DERIV_ENABLE  = 3'd5,
        REG_MEAN_MODE     = 3'd6,
        REG_ZERO_FILTER   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic start;
        logic neg;     // subtract the whole product
    } mul_ctl_t;

    typedef struct packed {
        logic add_new;
        logic shift;
    } win_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* rtl/pd_heading_controller.sv */
// ----------------------------------------------------------------------------
// pd_heading_controller
// PD heading controller with derivative window and output filter.
// One word in flight: the next input word is accepted once the controller
// returns to idle, as the drive word is registered. Each word uses the serial
// multiplier for five products (one when P only, which also skips the output
// filter). Output stalls hold the finished word and add to the word time.
// Reset clears the error window, filter history and control state and loads
// the default register values; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pd_heading_controller #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [31:0]                  target_heading,
    input  logic signed [31:0]                  measured_heading,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [31:0]                  drive,
    input  logic                                cfg_wr_en,
    input  logic [hdc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hdc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import hdc_pkg::*;

    localparam int DW = 34 + $clog2(WINDOW_DEPTH);
    localparam int AW = DW;
    localparam int PW = AW + MUL_BW;
    localparam int XW = PW - 15;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROP,
        S_PSAT,
        S_ERR,
        S_WIN_ADD,
        S_WIN_SHIFT,
        S_DERIV,
        S_XSUM,
        S_F1,
        S_F2,
        S_FRND,
        S_FOUT,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [30:0]          prop_gain_reg;
    logic [30:0]          deriv_gain_reg;
    logic [16:0]          lowpass_alpha_reg;
    logic signed [17:0]   zero_coef_reg;
    logic signed [17:0]   pole_coef_reg;
    logic                 deriv_en_reg;
    logic                 mean_mode_reg;
    logic                 zero_mode_reg;

    logic signed [32:0]   diff_reg;
    logic signed [XW-1:0] prop_reg;
    logic signed [XW-1:0] deriv_reg;
    logic signed [31:0]   err_reg;
    logic signed [31:0]   x_reg;
    logic signed [FILT_W-1:0] acc_reg;
    logic signed [FR_W-1:0]   fr_reg;
    logic signed [31:0]   fop_reg;
    logic signed [31:0]   fip_reg;
    logic signed [31:0]   res_reg;
    logic signed [31:0]   drive_reg;
    logic                 out_valid_reg;

    mul_ctl_t             mul_ctl_reg;
    win_ctl_t             win_ctl_reg;

    logic signed [AW-1:0]     mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic                     mul_done;
    logic signed [PW-1:0]     mul_prod;

    logic signed [DW-1:0]     d_mean;
    logic signed [DW-1:0]     d_end;

    logic signed [17:0]       lp_beta;
    logic [PW-1:0]            r_sum16;
    logic [PW-1:0]            r_sum28;
    logic [PW-1:0]            r_sum36;
    logic [FILT_W-1:0]        f_sum;
    logic signed [FILT_W-1:0] acc_sum;
    logic signed [31:0]       y;

    hdc_serial_mul #(
        .AW (AW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl_reg),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    hdc_err_window #(
        .DEPTH (WINDOW_DEPTH),
        .DW    (DW)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (win_ctl_reg),
        .err    (err_reg),
        .d_mean (d_mean),
        .d_end  (d_end)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        lp_beta = 18'(LP_ONE) - 18'(lowpass_alpha_reg);
        mul_a   = AW'(diff_reg);
        mul_b   = MUL_BW'({1'b0, prop_gain_reg});
        case (state_reg)
            S_ERR:
            begin
                mul_b = RAD2DEG_Q24;
            end
            S_DERIV:
            begin
                mul_a = mean_mode_reg ? d_mean : d_end;
                mul_b = MUL_BW'({1'b0, deriv_gain_reg});
            end
            S_F1:
            begin
                mul_a = zero_mode_reg ? AW'(fip_reg) : AW'(x_reg);
                mul_b = zero_mode_reg ? MUL_BW'(zero_coef_reg)
                                      : MUL_BW'({1'b0, lowpass_alpha_reg});
            end
            S_F2:
            begin
                mul_a = AW'(fop_reg);
                mul_b = zero_mode_reg ? MUL_BW'(pole_coef_reg) : MUL_BW'(lp_beta);
            end
            default:
            begin
                mul_a = AW'(diff_reg);
            end
        endcase
    end

    // round half away from zero: add half, less one when negative
    always_comb
    begin
        r_sum16 = mul_prod + (PW'(1) << 15) - PW'(mul_prod[PW-1]);
        r_sum28 = mul_prod + (PW'(1) << 27) - PW'(mul_prod[PW-1]);
        r_sum36 = mul_prod + (PW'(1) << 35) - PW'(mul_prod[PW-1]);
        f_sum   = acc_reg + (FILT_W'(1) << 15) - FILT_W'(acc_reg[FILT_W-1]);
        acc_sum = acc_reg + mul_prod[FILT_W-1:0];
        if (zero_mode_reg)
            y = sat32(64'(fr_reg) + 64'(x_reg));
        else
            y = sat32(64'(fr_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            mul_ctl_reg       <= '0;
            win_ctl_reg       <= '0;
            out_valid_reg     <= 1'b0;
            prop_gain_reg     <= 31'd10138009;
            deriv_gain_reg    <= '0;
            lowpass_alpha_reg <= 17'd16384;
            zero_coef_reg     <= 18'sd32768;
            pole_coef_reg     <= 18'sd32768;
            deriv_en_reg      <= 1'b1;
            mean_mode_reg     <= 1'b0;
            zero_mode_reg     <= 1'b0;
            fop_reg           <= '0;
            fip_reg           <= '0;
        end
        else
        begin
            mul_ctl_reg <= '0;
            win_ctl_reg <= '0;

            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:     prop_gain_reg     <= cfg_data[30:0];
                    REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data[30:0];
                    REG_LOWPASS_ALPHA: lowpass_alpha_reg <= cfg_data[16:0];
                    REG_ZERO_COEF:     zero_coef_reg     <= $signed(cfg_data[17:0]);
                    REG_POLE_COEF:     pole_coef_reg     <= $signed(cfg_data[17:0]);
                    REG_DERIV_ENABLE:  deriv_en_reg      <= cfg_data[0];
                    REG_MEAN_MODE:     mean_mode_reg     <= cfg_data[0];
                    REG_ZERO_FILTER:   zero_mode_reg     <= cfg_data[0];
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        diff_reg          <= 33'(target_heading) - 33'(measured_heading);
                        mul_ctl_reg.start <= 1'b1;
                        state_reg         <= S_PROP;
                    end
                end
                S_PROP:
                begin
                    if (mul_done)
                    begin
                        prop_reg <= XW'($signed(r_sum28[PW-1:28]));
                        if (deriv_en_reg)
                        begin
                            mul_ctl_reg.start <= 1'b1;
                            state_reg         <= S_ERR;
                        end
                        else
                            state_reg <= S_PSAT;
                    end
                end
                S_PSAT:
                begin
                    res_reg   <= sat32(64'(prop_reg));
                    state_reg <= S_DONE;
                end
                S_ERR:
                begin
                    if (mul_done)
                    begin
                        err_reg             <= 32'($signed(r_sum36[PW-1:36]));
                        win_ctl_reg.add_new <= 1'b1;
                        state_reg           <= S_WIN_ADD;
                    end
                end
                S_WIN_ADD:
                begin
                    win_ctl_reg.shift <= 1'b1;
                    state_reg         <= S_WIN_SHIFT;
                end
                S_WIN_SHIFT:
                begin
                    mul_ctl_reg.start <= 1'b1;
                    state_reg         <= S_DERIV;
                end
                S_DERIV:
                begin
                    if (mul_done)
                    begin
                        deriv_reg <= XW'($signed(r_sum16[PW-1:16]));
                        state_reg <= S_XSUM;
                    end
                end
                S_XSUM:
                begin
                    x_reg             <= sat32(64'(prop_reg + deriv_reg));
                    mul_ctl_reg.start <= 1'b1;
                    state_reg         <= S_F1;
                end
                S_F1:
                begin
                    if (mul_done)
                    begin
                        acc_reg           <= mul_prod[FILT_W-1:0];
                        mul_ctl_reg.start <= 1'b1;
                        mul_ctl_reg.neg   <= zero_mode_reg;
                        state_reg         <= S_F2;
                    end
                end
                S_F2:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= acc_sum;
                        state_reg <= S_FRND;
                    end
                end
                S_FRND:
                begin
                    fr_reg    <= $signed(f_sum[FILT_W-1:16]);
                    state_reg <= S_FOUT;
                end
                S_FOUT:
                begin
                    res_reg <= y;
                    fop_reg <= y;
                    if (zero_mode_reg)
                        fip_reg <= x_reg;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // output word free or leaving this cycle
                    if (!out_valid_reg || !out_stall)
                    begin
                        drive_reg     <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

endmodule

/* rtl/hdc_serial_mul.sv */
// ----------------------------------------------------------------------------
// hdc_serial_mul
// Bit-serial shift-add multiplier: parallel signed a, signed b taken one
// bit per cycle, LSB first, accumulator shifted right each step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdc_serial_mul #(
    parameter int AW = 38
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hdc_pkg::mul_ctl_t                 ctl,
    input  logic signed [AW-1:0]              a,
    input  logic signed [hdc_pkg::MUL_BW-1:0] b,
    output logic                              done,
    output logic signed [AW+hdc_pkg::MUL_BW-1:0] prod
);
    import hdc_pkg::*;

    logic signed [AW-1:0]  a_reg;
    logic signed [AW:0]    hi_reg;
    logic [MUL_BW-1:0]     lo_reg;
    logic [MUL_CNT_W-1:0]  cnt_reg;
    logic                  run_reg;
    logic                  neg_reg;
    logic                  done_reg;

    logic                  last;
    logic                  sub;
    logic signed [AW:0]    a_ext;
    logic signed [AW:0]    addend;
    logic signed [AW:0]    sum;

    always_comb
    begin
        last   = (cnt_reg == MUL_CNT_W'(MUL_BW - 1));
        // top bit of b carries negative weight
        sub    = neg_reg ^ last;
        a_ext  = (AW+1)'(a_reg);
        addend = lo_reg[0] ? (sub ? -a_ext : a_ext) : '0;
        sum    = hi_reg + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && last;
            if (ctl.start)
            begin
                a_reg   <= a;
                hi_reg  <= '0;
                lo_reg  <= b;
                neg_reg <= ctl.neg;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                hi_reg  <= sum >>> 1;
                lo_reg  <= {sum[0], lo_reg[MUL_BW-1:1]};
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                    run_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign prod = $signed({hi_reg[AW-1:0], lo_reg});

endmodule

/* rtl/hdc_err_window.sv */
// ----------------------------------------------------------------------------
// hdc_err_window
// Shift line of past errors with a running difference of the two
// half-window sums, updated in two steps per new error word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdc_err_window #(
    parameter int DEPTH = 8,
    parameter int DW    = 37
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hdc_pkg::win_ctl_t    ctl,
    input  logic signed [31:0]   err,
    output logic signed [DW-1:0] d_mean,
    output logic signed [DW-1:0] d_end
);
    import hdc_pkg::*;

    localparam int HALF = DEPTH / 2;

    logic signed [31:0]   win_reg [DEPTH];
    logic signed [DW-1:0] dsum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
                win_reg[k] <= '0;
            dsum_reg <= '0;
        end
        else
        begin
            if (ctl.add_new)
                dsum_reg <= dsum_reg + DW'(err) - DW'(win_reg[HALF-1]);
            else if (ctl.shift)
            begin
                // oldest leaves the old half, one word moves into it
                dsum_reg <= dsum_reg + DW'(win_reg[DEPTH-1])
                            - DW'(win_reg[DEPTH-HALF-1]);
                win_reg[0] <= err;
                for (int k = 1; k < DEPTH; k++)
                    win_reg[k] <= win_reg[k-1];
            end
        end
    end

    assign d_mean = dsum_reg;
    assign d_end  = DW'(win_reg[0]) - DW'(win_reg[DEPTH-1]);

endmodule
